>>> src/pns_pkg.sv
// Shared types and constants for the pressure noise statistics block.
package pns_pkg;

   localparam int COUNT_BITS    = 16;
   localparam int SAMPLE_W      = 21;
   localparam int TRUNC_W       = 17;
   localparam int ROUND_W       = 18;
   localparam int SUM_W         = 34;
   localparam int ENERGY_W      = 50;
   localparam int SQUARE_W      = 36;
   localparam int MEAN_W        = 17;
   localparam int RMS_W         = 21;
   localparam int SRC_W         = 58;
   localparam int REM_W         = 32;
   localparam int ALU_W         = 34;
   localparam int ROOT_W        = 30;
   localparam int STEP_BITS     = 6;
   localparam int MEAN_STEPS    = 34;
   localparam int ENERGY_STEPS  = 58;
   localparam int ROOT_STEPS    = 29;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 40;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [15:0]           WINDOW_RESET = 16'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN_DIV,
      ST_SQUARE,
      ST_ACCUM,
      ST_CHECK,
      ST_ENERGY_DIV,
      ST_ROOT,
      ST_REPORT
   } state_type;

endpackage

>>> src/pressure_noise_statistics.sv
// Sample without window close: 34 mean divide steps, then latch, square and accumulate;
// no new sample is accepted until the block is back in idle.
// Closing sample: 58 divide steps for energy/count, 29 root steps and a report state follow;
// the report state holds while the previous result still waits in the output register, and
// the next accept follows it. One shared 34-bit subtract-and-compare
// unit does every divide and root step. Synchronous active-high reset clears sums, count and
// result valid and sets the window length to 100; no clearing pass is needed.
module pressure_noise_statistics (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [20:0] pressure_q4, [23:21] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pns_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: [16:0] mean_pa, [37:17] rms_x16, [39:38] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pns_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // csr_data: window_length
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [15:0]                       csr_data
);

   pns_pkg::state_type state_ff, state_in;

   logic [15:0]                       win_ff, win_in;
   logic [pns_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic [pns_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic [pns_pkg::ENERGY_W-1:0]      energy_ff, energy_in;
   logic [pns_pkg::ROUND_W-1:0]       rounded_ff, rounded_in;
   logic [pns_pkg::MEAN_W-1:0]        mean_ff, mean_in;
   logic [pns_pkg::SQUARE_W-1:0]      sq_ff, sq_in;
   logic [pns_pkg::SRC_W-1:0]         src_ff, src_in;
   logic [pns_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [pns_pkg::ROOT_W-1:0]        root_ff, root_in;
   logic [pns_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pns_pkg::MEAN_W-1:0]        rsp_mean_ff, rsp_mean_in;
   logic [pns_pkg::RMS_W-1:0]         rsp_rms_ff, rsp_rms_in;

   logic                              accept;
   logic [pns_pkg::SAMPLE_W-1:0]      sample;
   logic [pns_pkg::SUM_W-1:0]         sum_add;
   logic [pns_pkg::COUNT_BITS-1:0]    count_inc;
   logic [pns_pkg::ROUND_W-1:0]       rounded_new;
   logic [pns_pkg::ROUND_W:0]         diff;
   logic [pns_pkg::ROUND_W-1:0]       mag;
   logic [15:0]                       limit;
   logic                              window_end;
   logic                              step_last;
   logic                              out_free;

   // shared subtract-and-compare unit
   logic                              alu_root;
   logic [pns_pkg::ALU_W-1:0]         alu_rem_sh;
   logic [pns_pkg::ALU_W-1:0]         alu_operand;
   logic [pns_pkg::ALU_W:0]           alu_diff;
   logic                              alu_ge;
   logic [pns_pkg::REM_W-1:0]         alu_rem_next;

   assign req_tready = (state_ff == pns_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // take a window write only between samples, never beside a sample beat
   assign csr_ready  = (state_ff == pns_pkg::ST_IDLE) && !req_tvalid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_rms_ff, rsp_mean_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign sample      = req_tdata[pns_pkg::SAMPLE_W-1:0];
   assign sum_add     = sum_ff + {{(pns_pkg::SUM_W-pns_pkg::TRUNC_W){1'b0}}, sample[20:4]};
   assign count_inc   = (count_ff == pns_pkg::COUNT_MAX) ? pns_pkg::COUNT_BITS'(1)
                                                         : count_ff + 1'b1;
   assign rounded_new = 18'(({1'b0, sample} + 22'd8) >> 4);

   assign diff = {1'b0, rounded_ff} - {2'b00, mean_ff};
   assign mag  = diff[pns_pkg::ROUND_W] ? 18'(-diff) : diff[pns_pkg::ROUND_W-1:0];

   // a zero window means every sample reports
   assign limit      = (win_ff == 16'd0) ? 16'd1 : win_ff;
   assign window_end = (16'(count_ff) >= limit) || (count_ff == pns_pkg::COUNT_MAX);

   always_comb begin
      alu_root = (state_ff == pns_pkg::ST_ROOT);
      if (alu_root) begin
         alu_rem_sh  = {rem_ff, src_ff[pns_pkg::SRC_W-1 -: 2]};
         alu_operand = {2'b00, root_ff, 2'b01};
      end else begin
         alu_rem_sh  = {1'b0, rem_ff, src_ff[pns_pkg::SRC_W-1]};
         alu_operand = {{(pns_pkg::ALU_W-pns_pkg::COUNT_BITS){1'b0}}, count_ff};
      end
      alu_diff     = {1'b0, alu_rem_sh} - {1'b0, alu_operand};
      alu_ge       = !alu_diff[pns_pkg::ALU_W];
      alu_rem_next = alu_ge ? alu_diff[pns_pkg::REM_W-1:0] : alu_rem_sh[pns_pkg::REM_W-1:0];
   end

   always_comb begin
      case (state_ff)
         pns_pkg::ST_MEAN_DIV:
            step_last = (step_ff == pns_pkg::STEP_BITS'(pns_pkg::MEAN_STEPS - 1));
         pns_pkg::ST_ENERGY_DIV:
            step_last = (step_ff == pns_pkg::STEP_BITS'(pns_pkg::ENERGY_STEPS - 1));
         pns_pkg::ST_ROOT:
            step_last = (step_ff == pns_pkg::STEP_BITS'(pns_pkg::ROOT_STEPS - 1));
         default:
            step_last = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pns_pkg::ST_IDLE:       if (accept) state_in = pns_pkg::ST_MEAN_DIV;
         pns_pkg::ST_MEAN_DIV:   if (step_last) state_in = pns_pkg::ST_SQUARE;
         pns_pkg::ST_SQUARE:     state_in = pns_pkg::ST_ACCUM;
         pns_pkg::ST_ACCUM:      state_in = pns_pkg::ST_CHECK;
         pns_pkg::ST_CHECK:      state_in = window_end ? pns_pkg::ST_ENERGY_DIV
                                                       : pns_pkg::ST_IDLE;
         pns_pkg::ST_ENERGY_DIV: if (step_last) state_in = pns_pkg::ST_ROOT;
         pns_pkg::ST_ROOT:       if (step_last) state_in = pns_pkg::ST_REPORT;
         pns_pkg::ST_REPORT:     if (out_free) state_in = pns_pkg::ST_IDLE;
         default:                state_in = pns_pkg::ST_IDLE;
      endcase
   end

   // datapath per state
   always_comb begin
      win_in       = win_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      energy_in    = energy_ff;
      rounded_in   = rounded_ff;
      mean_in      = mean_ff;
      sq_in        = sq_ff;
      src_in       = src_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_rms_in   = rsp_rms_ff;

      if (csr_valid && csr_ready) begin
         win_in = csr_data;
      end

      case (state_ff)
         pns_pkg::ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               sum_in     = sum_add;
               count_in   = count_inc;
               rounded_in = rounded_new;
               src_in     = {sum_add, {(pns_pkg::SRC_W-pns_pkg::SUM_W){1'b0}}};
               rem_in     = '0;
            end
         end
         pns_pkg::ST_MEAN_DIV, pns_pkg::ST_ENERGY_DIV: begin
            rem_in = alu_rem_next;
            src_in = {src_ff[pns_pkg::SRC_W-2:0], alu_ge};
            if (step_last) begin
               step_in = '0;
               rem_in  = '0;
               root_in = '0;
            end
         end
         pns_pkg::ST_SQUARE: begin
            // quotient of the mean divide sits in the low bits
            mean_in = src_ff[pns_pkg::MEAN_W-1:0];
         end
         pns_pkg::ST_ACCUM: begin
            sq_in = mag * mag;
         end
         pns_pkg::ST_CHECK: begin
            energy_in = energy_ff + pns_pkg::ENERGY_W'(sq_ff);
            step_in   = '0;
            rem_in    = '0;
            src_in    = {energy_ff + pns_pkg::ENERGY_W'(sq_ff),
                         {(pns_pkg::SRC_W-pns_pkg::ENERGY_W){1'b0}}};
         end
         pns_pkg::ST_ROOT: begin
            rem_in  = alu_rem_next;
            src_in  = {src_ff[pns_pkg::SRC_W-3:0], 2'b00};
            root_in = {root_ff[pns_pkg::ROOT_W-2:0], alu_ge};
         end
         pns_pkg::ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_rms_in   = (root_ff[pns_pkg::ROOT_W-1:pns_pkg::RMS_W] != '0)
                              ? {pns_pkg::RMS_W{1'b1}} : root_ff[pns_pkg::RMS_W-1:0];
               sum_in       = '0;
               count_in     = '0;
               energy_in    = '0;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pns_pkg::ST_IDLE;
         win_ff       <= pns_pkg::WINDOW_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         energy_ff    <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         energy_ff    <= energy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rounded_ff  <= rounded_in;
      mean_ff     <= mean_in;
      sq_ff       <= sq_in;
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_rms_ff  <= rsp_rms_in;
   end

   // partial remainder of a divide always stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pns_pkg::ST_MEAN_DIV || state_ff == pns_pkg::ST_ENERGY_DIV)
      |-> (pns_pkg::REM_W'(count_ff) > rem_ff))
      else $error("divide remainder not below sample count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != pns_pkg::ST_IDLE) |-> (count_ff != '0))
      else $error("sample count zero while a sample is in work");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pns_pkg::ST_REPORT && out_free)
      |=> (count_ff == '0 && sum_ff == '0 && energy_ff == '0 && rsp_valid_ff))
      else $error("store not cleared after report");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == pns_pkg::ST_REPORT))
      else $error("result raised outside report");

endmodule
